@@ hdl/mira_pkg.sv @@
// shared types and constants for the modulated ir ambient rejection block
`timescale 1ns / 1ps
`default_nettype none

package mira_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CH_W      = 3;
    localparam int MEAN_W    = 12;
    localparam int INT_W     = 13;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef struct packed
    {
        logic signed [INT_W-1:0] intensity;
        logic                    led_on;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/mira_ring_ram.sv @@
// single port write, single port read sample ring memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mira_ring_ram #(
    parameter int DEPTH  = 5120,
    parameter int ADDR_W = 13,
    parameter int WIDTH  = 12
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/mira_mean.sv @@
// per channel running mean registers, sum divided by the window via a reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module mira_mean #(
    parameter int CHANNELS = 5,
    parameter int WINDOW   = 1024,
    parameter int CH_IDX_W = 3,
    parameter int SUM_W    = 22
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                upd_en,
    input  wire logic [CH_IDX_W-1:0] upd_ch,
    input  wire logic [SUM_W-1:0]    upd_sum,
    output logic      [11:0]         means [CHANNELS]
);

    import mira_pkg::*;

    localparam int LOG_W = $clog2(WINDOW);
    localparam int SHIFT = SUM_W + LOG_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
    localparam int PROD_W = 2 * SUM_W + 1;

    logic [PROD_W-1:0] product;
    logic [MEAN_W-1:0] mean_new;
    logic [MEAN_W-1:0] means_reg [CHANNELS];

    // exact truncating quotient for any sum below 2**SUM_W
    assign product  = PROD_W'(upd_sum) * PROD_W'(RECIP);
    assign mean_new = product[SHIFT +: MEAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                means_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            means_reg[upd_ch] <= mean_new;
        end
    end

    assign means = means_reg;

endmodule

`default_nettype wire

@@ hdl/mira_out_fifo.sv @@
// small result queue between the update pipeline and the master side
`timescale 1ns / 1ps
`default_nettype none

module mira_out_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire mira_pkg::result_t          push_data,
    output logic                            pop_valid,
    input  wire logic                       pop_ready,
    output mira_pkg::result_t               pop_data,
    output logic [mira_pkg::OUT_CNT_W-1:0]  count
);

    import mira_pkg::*;

    result_t                entry [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underflow");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ hdl/modulated_ir_ambient_rejection.sv @@
// top level: sample ring update pipeline, phase banks and result output
//
// usage
//   slave side takes one transaction per cycle when ready: tdata carries the channel
//   and the 12-bit sample, tuser the operation (store a sample or a phase tick)
//   master side gives one result per input transaction, in order: tdata holds the
//   signed on-mean minus off-mean of the named channel (zero for one out of range),
//   tuser the led phase after that item
//   each item passes stage 1, stage 2 and the result queue before it reaches the
//   master side; throughput is one item per cycle when ready, set by the single
//   write port of the ring memory that each sample reads and writes back once
//   after reset the ring memory is swept to zero, one entry a cycle, over all
//   CHANNELS * WINDOW entries (5120 at the defaults); s_axis_tready stays low
//   until the sweep ends
//   when the master side stalls, results collect in a four entry queue and
//   s_axis_tready falls once the queue plus the items still in flight fill it,
//   so nothing is dropped; it rises again in the cycle after a result is taken
//   a sample back to back with one for the same ring entry takes its old value
//   from the forwarding path instead of the memory
`timescale 1ns / 1ps
`default_nettype none

module modulated_ir_ambient_rejection #(
    parameter int CHANNELS = 5,
    parameter int WINDOW   = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // slave side
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // channel [2:0], sample [14:3], zero [15]
    input  wire logic [mira_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // operation [0]
    input  wire logic                            s_axis_tuser,
    // master side
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // intensity [12:0], zero [15:13]
    output logic [mira_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // led_on [0]
    output logic                                 m_axis_tuser
);

    import mira_pkg::*;

    localparam int LOG_W      = $clog2(WINDOW);
    localparam int SUM_W      = SAMPLE_W + LOG_W;
    localparam int ROW_W      = (WINDOW > 1) ? LOG_W : 1;
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // input decode
    logic                in_accept;
    op_t                 in_op;
    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_smp;
    logic                in_ch_ok;
    logic [CH_IDX_W-1:0] in_ch_idx;
    logic                in_wr;
    logic [ADDR_W-1:0]   in_idx;

    // ring sweep after reset
    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;

    // scan row
    logic [ROW_W-1:0]    scan_reg;
    logic [ROW_W-1:0]    scan_next;

    // stage 1: memory data back, sum update, write back
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic                s1_ch_ok_reg;
    logic [CH_IDX_W-1:0] s1_ch_reg;
    logic                s1_wr_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic [SAMPLE_W-1:0] s1_smp_reg;
    logic                s1_fwd_reg;
    logic [SAMPLE_W-1:0] s1_fwd_data_reg;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic [SAMPLE_W-1:0] s1_old;
    logic [SUM_W-1:0]    s1_sum_next;
    logic [SUM_W-1:0]    sums_reg [CHANNELS];

    // stage 2: mean update, tick, result
    logic                s2_valid_reg;
    op_t                 s2_op_reg;
    logic                s2_ch_ok_reg;
    logic [CH_IDX_W-1:0] s2_ch_reg;
    logic                s2_wr_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [MEAN_W-1:0]   cur_means [CHANNELS];
    logic [MEAN_W-1:0]   on_bank_reg  [CHANNELS];
    logic [MEAN_W-1:0]   off_bank_reg [CHANNELS];
    logic                phase_reg;
    logic                s2_tick;
    logic                phase_next;
    logic [MEAN_W-1:0]   on_sel;
    logic [MEAN_W-1:0]   off_sel;
    logic [INT_W-1:0]    diff;
    result_t             result;

    // memory ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;

    // output queue
    result_t              q_data;
    logic [OUT_CNT_W-1:0] q_count;
    logic [OUT_CNT_W-1:0] in_flight;

    // ---------------------------------------------------------------- input side
    assign in_op     = op_t'(s_axis_tuser);
    assign in_ch     = s_axis_tdata[CH_W-1:0];
    assign in_smp    = s_axis_tdata[CH_W +: SAMPLE_W];
    assign in_ch_ok  = (32'(in_ch) < CHANNELS);
    assign in_ch_idx = in_ch_ok ? CH_IDX_W'(in_ch) : '0;
    assign in_wr     = (in_op == OP_SAMPLE) && in_ch_ok;
    assign in_idx    = ADDR_W'(ADDR_W'(scan_reg) * ADDR_W'(CHANNELS)) + ADDR_W'(in_ch_idx);

    // credit: queue entries plus the two stages still in flight
    assign in_flight = q_count + OUT_CNT_W'(s1_valid_reg) + OUT_CNT_W'(s2_valid_reg);
    assign s_axis_tready = !clearing_reg && (in_flight < OUT_CNT_W'(OUT_DEPTH));
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // only the last channel moves the scan row on
    always_comb
    begin
        scan_next = scan_reg;
        if (in_accept && in_wr && (32'(in_ch) == CHANNELS - 1))
        begin
            if (scan_reg == ROW_W'(WINDOW - 1))
            begin
                scan_next = '0;
            end
            else
            begin
                scan_next = scan_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            scan_reg     <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(RING_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            scan_reg <= scan_next;
        end
    end

    // ---------------------------------------------------------------- ring memory
    assign ram_we    = clearing_reg || (s1_valid_reg && s1_wr_reg);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : s1_idx_reg;
    assign ram_wdata = clearing_reg ? '0 : s1_smp_reg;

    mira_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (SAMPLE_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_idx),
        .rdata (ring_rdata)
    );

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg       <= in_op;
            s1_ch_ok_reg    <= in_ch_ok;
            s1_ch_reg       <= in_ch_idx;
            s1_wr_reg       <= in_wr;
            s1_idx_reg      <= in_idx;
            s1_smp_reg      <= in_smp;
            // entry being written back this very edge is read stale by the memory
            s1_fwd_reg      <= s1_valid_reg && s1_wr_reg && (s1_idx_reg == in_idx);
            s1_fwd_data_reg <= s1_smp_reg;
        end
    end

    assign s1_old      = s1_fwd_reg ? s1_fwd_data_reg : ring_rdata;
    assign s1_sum_next = sums_reg[s1_ch_reg] - SUM_W'(s1_old) + SUM_W'(s1_smp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg && s1_wr_reg)
        begin
            sums_reg[s1_ch_reg] <= s1_sum_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_ch_ok_reg <= s1_ch_ok_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_wr_reg    <= s1_wr_reg;
            s2_sum_reg   <= s1_sum_next;
        end
    end

    // mean of each channel follows its sum one stage later
    mira_mean #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW),
        .CH_IDX_W (CH_IDX_W),
        .SUM_W    (SUM_W)
    ) u_mean (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd_en  (s2_valid_reg && s2_wr_reg),
        .upd_ch  (s2_ch_reg),
        .upd_sum (s2_sum_reg),
        .means   (cur_means)
    );

    assign s2_tick    = s2_valid_reg && (s2_op_reg == OP_TICK);
    assign phase_next = s2_tick ? !phase_reg : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                on_bank_reg[i]  <= '0;
                off_bank_reg[i] <= '0;
            end
        end
        else
        begin
            if (s2_tick)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (phase_reg)
                    begin
                        on_bank_reg[i] <= cur_means[i];
                    end
                    else
                    begin
                        off_bank_reg[i] <= cur_means[i];
                    end
                end
            end
            phase_reg <= phase_next;
        end
    end

    // banks as they stand after this item
    assign on_sel  = (s2_tick && phase_reg) ? cur_means[s2_ch_reg] : on_bank_reg[s2_ch_reg];
    assign off_sel = (s2_tick && !phase_reg) ? cur_means[s2_ch_reg] : off_bank_reg[s2_ch_reg];
    assign diff    = INT_W'(on_sel) - INT_W'(off_sel);

    always_comb
    begin
        result.intensity = s2_ch_ok_reg ? $signed(diff) : '0;
        result.led_on    = phase_next;
    end

    // ---------------------------------------------------------------- output side
    mira_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (result),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (q_data),
        .count     (q_count)
    );

    assign m_axis_tdata = {{(M_DATA_W - INT_W){1'b0}}, q_data.intensity};
    assign m_axis_tuser = q_data.led_on;

`ifndef SYNTHESIS
    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg && !s2_valid_reg)
        else $error("item in flight during ring sweep");
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_reg) < WINDOW)
        else $error("scan row out of range");
    a_phase_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s2_tick |=> phase_reg != $past(phase_reg))
        else $error("tick did not toggle phase");
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_tick |=> phase_reg == $past(phase_reg))
        else $error("phase changed without a tick");
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> q_count + OUT_CNT_W'(s1_valid_reg) + OUT_CNT_W'(s2_valid_reg)
            <= OUT_CNT_W'(OUT_DEPTH))
        else $error("more items in flight than queue space");
`endif

endmodule

`default_nettype wire

@@ sim/mira_checker.sv @@
// checker: predicts every detector reading from the slave side and compares it with the master side
`timescale 1ns / 1ps

module mira_checker #(
    parameter int CHANNELS = 5,
    parameter int WINDOW   = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [mira_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [mira_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tuser,
    output int                            mismatches,
    output int                            readings_due
);

    import mira_pkg::*;

    localparam int SUM_W     = 22;
    localparam int MAX_LINES = 40;

    // own copy of the detector state
    logic [SAMPLE_W-1:0] ring [CHANNELS*WINDOW];
    logic [SUM_W-1:0]    window_total [CHANNELS];
    logic [MEAN_W-1:0]   lit_mean [CHANNELS];
    logic [MEAN_W-1:0]   dark_mean [CHANNELS];
    int unsigned         scan_row;
    logic                lit_phase;

    // readings still to come out of the master side, oldest first
    result_t             due_readings [$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_LINES)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // fold one transaction into the state and queue the reading it gives
    task automatic detect_item(input op_t op, input logic [CH_W-1:0] ch,
                               input logic [SAMPLE_W-1:0] smp);
        int unsigned entry;
        int          i;
        int          diff;
        result_t     reading;
        diff = 0;
        if (op == OP_SAMPLE)
        begin
            if (ch < CHANNELS)
            begin
                entry = scan_row * CHANNELS + ch;
                window_total[ch] = window_total[ch] - ring[entry] + smp;
                ring[entry] = smp;
                // only the last channel moves the scan on
                if (ch == CHANNELS - 1)
                    scan_row = (scan_row + 1 == WINDOW) ? 0 : scan_row + 1;
            end
        end
        else
        begin
            for (i = 0; i < CHANNELS; i++)
            begin
                if (lit_phase)
                    lit_mean[i] = MEAN_W'(window_total[i] / WINDOW);
                else
                    dark_mean[i] = MEAN_W'(window_total[i] / WINDOW);
            end
            lit_phase = ~lit_phase;
        end
        if (ch < CHANNELS)
            diff = int'(lit_mean[ch]) - int'(dark_mean[ch]);
        reading.intensity = diff[INT_W-1:0];
        reading.led_on    = lit_phase;
        due_readings.push_back(reading);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t wanted;
        logic signed [INT_W-1:0] got_intensity;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS*WINDOW; i++)
                ring[i] = '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                window_total[i] = '0;
                lit_mean[i]     = '0;
                dark_mean[i]    = '0;
            end
            scan_row   = 0;
            lit_phase  = 1'b1;
            mismatches = 0;
            due_readings.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_intensity = m_axis_tdata[INT_W-1:0];
                if (due_readings.size() == 0)
                    report_mismatch("result transaction with no reading outstanding");
                else
                begin
                    wanted = due_readings.pop_front();
                    if (got_intensity !== wanted.intensity)
                        report_mismatch($sformatf("intensity expected %0d got %0d",
                                                  wanted.intensity, got_intensity));
                    if (m_axis_tuser !== wanted.led_on)
                        report_mismatch($sformatf("led_on expected %0b got %0b",
                                                  wanted.led_on, m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                detect_item(op_t'(s_axis_tuser), s_axis_tdata[CH_W-1:0],
                            s_axis_tdata[CH_W +: SAMPLE_W]);
        end
        readings_due = due_readings.size();
    end

endmodule

@@ sim/testbench.sv @@
// testbench top: clock, reset, sample and tick stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench;

    import mira_pkg::*;

    localparam int CHANNELS     = 5;
    localparam int WINDOW       = 1024;
    localparam int LAST_CH      = CHANNELS - 1;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // channel [2:0], sample [14:3], zero [15]
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // operation [0]
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // intensity [12:0], zero [15:13]
    logic [M_DATA_W-1:0] m_axis_tdata;
    // led_on [0]
    logic                m_axis_tuser;

    int                  mismatches;
    int                  readings_due;
    int                  cycles        = 0;
    int                  items_sent    = 0;
    int                  send_gap_pct  = 19;
    int                  recv_gap_pct  = 79;
    logic                stall_armed   = 1'b0;
    logic                receiver_hold = 1'b0;

    modulated_ir_ambient_rejection #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mira_checker #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .readings_due  (readings_due)
    );

    always #4 clk = ~clk;

    // watchdog, sized for the ring sweep plus a slow run several times over
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (receiver_hold)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // long hold-off so the output queue fills and the slave side stalls
    initial
    begin
        wait (stall_armed);
        repeat (40) @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    // one transaction on the slave side, with random idle cycles in front
    task automatic send_item(input op_t op, input int ch, input int smp);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, SAMPLE_W'(smp), CH_W'(ch)};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // converter reading with the rails well represented
    function automatic int draw_reading();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 0;
        else if (pick < 20)
            return 4095;
        return $urandom_range(0, 4095);
    endfunction

    initial
    begin
        int pick;
        int run_len;
        int level;
        int ch;
        int random_start;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rails, both phases, stale and foreign channels, same-entry rewrites
        send_item(OP_SAMPLE, 0, 4095);
        send_item(OP_SAMPLE, 1, 0);
        send_item(OP_SAMPLE, 2, 4095);
        send_item(OP_SAMPLE, 3, 12'hAAA);
        send_item(OP_SAMPLE, LAST_CH, 12'h555);
        send_item(OP_TICK, 0, 0);
        send_item(OP_TICK, 0, 4095);
        send_item(OP_SAMPLE, 0, 4095);
        send_item(OP_SAMPLE, 0, 4095);
        send_item(OP_SAMPLE, 0, 0);
        send_item(OP_SAMPLE, 5, 4095);
        send_item(OP_SAMPLE, 6, 1);
        send_item(OP_SAMPLE, 7, 4095);
        send_item(OP_TICK, 7, 4095);
        send_item(OP_TICK, 5, 12'h800);
        send_item(OP_SAMPLE, 3, 4095);
        send_item(OP_SAMPLE, LAST_CH, 4095);
        send_item(OP_SAMPLE, LAST_CH, 4095);
        send_item(OP_TICK, LAST_CH, 0);
        send_item(OP_TICK, 2, 0);

        // random: mostly long runs on the last channel so the scan wraps the ring,
        // with full scans, ticks, same-entry rewrites and noise mixed in
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start >= 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
                stall_armed  = 1'b1;
            end
            else if (items_sent - random_start >= RANDOM_ITEMS / 3)
            begin
                send_gap_pct = 79;
                recv_gap_pct = 19;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                run_len = $urandom_range(16, 64);
                level   = draw_reading();
                repeat (run_len)
                begin
                    if ($urandom_range(0, 99) < 5)
                        send_item(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 4095));
                    else if ($urandom_range(0, 1) == 0)
                        send_item(OP_SAMPLE, LAST_CH, level);
                    else
                        send_item(OP_SAMPLE, LAST_CH, draw_reading());
                end
            end
            else if (pick < 65)
            begin
                for (ch = 0; ch < CHANNELS; ch++)
                    send_item(OP_SAMPLE, ch, draw_reading());
            end
            else if (pick < 82)
                send_item(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 4095));
            else if (pick < 91)
            begin
                ch = $urandom_range(0, LAST_CH - 1);
                repeat ($urandom_range(2, 4))
                    send_item(OP_SAMPLE, ch, draw_reading());
            end
            else
                send_item(op_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                          $urandom_range(0, 4095));
        end
        s_axis_tvalid <= 1'b0;

        // let every outstanding reading drain, then a few quiet cycles
        @(negedge clk);
        while (readings_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mira_pkg.sv
hdl/mira_ring_ram.sv
hdl/mira_mean.sv
hdl/mira_out_fifo.sv
hdl/modulated_ir_ambient_rejection.sv
sim/mira_checker.sv
sim/testbench.sv
